[rtl/core/neighbour_frame_capture_sequencer_assert.svh]
// Assertion macros for the neighbour frame capture sequencer.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef NEIGHBOUR_FRAME_CAPTURE_SEQUENCER_ASSERT_SVH
`define NEIGHBOUR_FRAME_CAPTURE_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define NFCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nfcs assertion failed");

// Next-cycle implication.
`define NFCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nfcs assertion failed");

`endif

[rtl/core/nfcs_pkg.sv]
// Shared types and codes for the neighbour frame capture sequencer.
// No dependencies.
package nfcs_pkg;

  localparam int TOTAL_WIDTH = 32;
  localparam int TICK_WIDTH  = 32;

  typedef enum logic [1:0] {
    STAGE_IDLE   = 2'd0,
    STAGE_BEFORE = 2'd1,
    STAGE_FOLLOW = 2'd2
  } stage_t;

  localparam logic [2:0] REQ_ARM        = 3'd0;
  localparam logic [2:0] REQ_TICK_START = 3'd1;
  localparam logic [2:0] REQ_INBETWEEN  = 3'd2;
  localparam logic [2:0] REQ_FRAME_COPY = 3'd3;
  localparam logic [2:0] REQ_TICK_END   = 3'd4;

  localparam logic [1:0] SLOT_BEFORE    = 2'd0;
  localparam logic [1:0] SLOT_INBETWEEN = 2'd1;
  localparam logic [1:0] SLOT_AFTER     = 2'd2;

  localparam logic [1:0] DONE_NONE      = 2'd0;
  localparam logic [1:0] DONE_COMPLETED = 2'd1;
  localparam logic [1:0] DONE_REFUSED   = 2'd2;

  localparam logic [2:0] CAPTURE_MAX    = 3'd7;
  localparam logic [2:0] BEFORE_CAPTURES = 3'd1;
  localparam logic [2:0] ALL_CAPTURES   = 3'd3;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [TICK_WIDTH-1:0] tick_number;
    logic                  capture_ok;
  } event_t;

  typedef struct packed {
    logic                   arm_granted;
    logic                   capture_request;
    logic [1:0]             capture_slot;
    logic [1:0]             sequence_done;
    logic [1:0]             current_stage;
    logic [TOTAL_WIDTH-1:0] completed_total;
    logic [TOTAL_WIDTH-1:0] refused_total;
    logic [TOTAL_WIDTH-1:0] restarted_total;
  } result_t;

endpackage

[rtl/core/nfcs_in_reg.sv]
// Input register for the capture sequencer: holds one request until the engine takes it.
// Depends on nfcs_pkg.
module nfcs_in_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  nfcs_pkg::event_t       ev_in,
  input  logic                   advance,
  output logic                   held_valid,
  output nfcs_pkg::event_t       ev_held
);
  import nfcs_pkg::*;

  logic   held;
  event_t ev_q;

  assign in_ready   = !held || advance;
  assign held_valid = held;
  assign ev_held    = ev_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_q <= ev_in;
    end
  end

endmodule

[rtl/core/nfcs_engine.sv]
// Sequencer state and the single-pass update for one request.
// Depends on nfcs_pkg and the assertion macro header.
`include "neighbour_frame_capture_sequencer_assert.svh"

module nfcs_engine #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  nfcs_pkg::event_t  ev,
  output nfcs_pkg::result_t res
);
  import nfcs_pkg::*;

  logic                   request_pending, request_pending_next;
  stage_t                 stage, stage_next;
  stage_t                 running_stage, running_stage_next;
  logic [TICK_WIDTH-1:0]  before_tick, before_tick_next;
  logic                   capture_failed, capture_failed_next;
  logic [2:0]             capture_count, capture_count_next;
  logic [COUNT_WIDTH-1:0] completed_count, completed_count_next;
  logic [COUNT_WIDTH-1:0] refused_count, refused_count_next;
  logic [COUNT_WIDTH-1:0] restart_count, restart_count_next;

  stage_t     start_stage;
  logic       restart_hit;
  logic       cap_req;
  logic [1:0] cap_slot;
  logic [1:0] done;
  logic       granted;

  // Stage a tick start would land in.
  always_comb begin
    start_stage = stage;
    restart_hit = 1'b0;
    if (stage == STAGE_IDLE && request_pending) begin
      start_stage = STAGE_BEFORE;
    end else if (stage == STAGE_FOLLOW && ev.tick_number != before_tick + 32'd1) begin
      start_stage = STAGE_BEFORE;
      restart_hit = 1'b1;
    end
  end

  // Capture asked for by this request, if any.
  always_comb begin
    cap_req  = 1'b0;
    cap_slot = SLOT_BEFORE;
    if (ev.req_type == REQ_INBETWEEN && running_stage == STAGE_FOLLOW) begin
      cap_req  = 1'b1;
      cap_slot = SLOT_INBETWEEN;
    end else if (ev.req_type == REQ_FRAME_COPY) begin
      if (running_stage == STAGE_BEFORE) begin
        cap_req = 1'b1;
      end else if (running_stage == STAGE_FOLLOW) begin
        cap_req  = 1'b1;
        cap_slot = SLOT_AFTER;
      end
    end
  end

  always_comb begin
    request_pending_next = request_pending;
    stage_next           = stage;
    running_stage_next   = running_stage;
    before_tick_next     = before_tick;
    capture_failed_next  = capture_failed;
    capture_count_next   = capture_count;
    completed_count_next = completed_count;
    refused_count_next   = refused_count;
    restart_count_next   = restart_count;
    granted              = 1'b0;
    done                 = DONE_NONE;

    if (cap_req) begin
      if (!ev.capture_ok) begin
        capture_failed_next = 1'b1;
      end else if (capture_count != CAPTURE_MAX) begin
        capture_count_next = capture_count + 3'd1;
      end
    end

    unique case (ev.req_type)
      REQ_ARM: begin
        if (!request_pending) begin
          request_pending_next = 1'b1;
          granted              = 1'b1;
        end
      end
      REQ_TICK_START: begin
        stage_next         = start_stage;
        running_stage_next = start_stage;
        if (restart_hit && !(&restart_count)) begin
          restart_count_next = restart_count + COUNT_WIDTH'(1);
        end
        if (start_stage == STAGE_BEFORE) begin
          before_tick_next    = ev.tick_number;
          capture_failed_next = 1'b0;
          capture_count_next  = '0;
        end
      end
      REQ_TICK_END: begin
        if (running_stage == STAGE_BEFORE) begin
          running_stage_next = STAGE_IDLE;
          if (capture_failed || capture_count != BEFORE_CAPTURES) begin
            done = DONE_REFUSED;
          end else begin
            stage_next = STAGE_FOLLOW;
          end
        end else if (running_stage == STAGE_FOLLOW) begin
          running_stage_next = STAGE_IDLE;
          done = (!capture_failed && capture_count == ALL_CAPTURES) ?
                 DONE_COMPLETED : DONE_REFUSED;
        end
        if (done != DONE_NONE) begin
          stage_next           = STAGE_IDLE;
          request_pending_next = 1'b0;
        end
        if (done == DONE_COMPLETED && !(&completed_count)) begin
          completed_count_next = completed_count + COUNT_WIDTH'(1);
        end
        if (done == DONE_REFUSED && !(&refused_count)) begin
          refused_count_next = refused_count + COUNT_WIDTH'(1);
        end
      end
      default: begin
        // in-between, frame copy and unknown codes touch only the capture state
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_pending <= 1'b0;
      stage           <= STAGE_IDLE;
      running_stage   <= STAGE_IDLE;
      before_tick     <= '0;
      capture_failed  <= 1'b0;
      capture_count   <= '0;
      completed_count <= '0;
      refused_count   <= '0;
      restart_count   <= '0;
    end else if (fire) begin
      request_pending <= request_pending_next;
      stage           <= stage_next;
      running_stage   <= running_stage_next;
      before_tick     <= before_tick_next;
      capture_failed  <= capture_failed_next;
      capture_count   <= capture_count_next;
      completed_count <= completed_count_next;
      refused_count   <= refused_count_next;
      restart_count   <= restart_count_next;
    end
  end

  logic [TOTAL_WIDTH-1:0] completed_out, refused_out, restart_out;

  generate
    if (COUNT_WIDTH >= TOTAL_WIDTH) begin : g_trunc
      assign completed_out = completed_count_next[TOTAL_WIDTH-1:0];
      assign refused_out   = refused_count_next[TOTAL_WIDTH-1:0];
      assign restart_out   = restart_count_next[TOTAL_WIDTH-1:0];
    end else begin : g_ext
      assign completed_out = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, completed_count_next};
      assign refused_out   = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, refused_count_next};
      assign restart_out   = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, restart_count_next};
    end
  endgenerate

  always_comb begin
    res.arm_granted     = granted;
    res.capture_request = cap_req;
    res.capture_slot    = cap_slot;
    res.sequence_done   = done;
    res.current_stage   = stage_next;
    res.completed_total = completed_out;
    res.refused_total   = refused_out;
    res.restarted_total = restart_out;
  end

  `NFCS_ASSERT_NOW(a_active_needs_pending, stage != STAGE_IDLE, request_pending)
  `NFCS_ASSERT_NOW(a_running_tracks_stage, running_stage != STAGE_IDLE,
                   running_stage == stage)
  `NFCS_ASSERT_NEXT(a_completion_counted, fire && done == DONE_COMPLETED,
                    completed_count != '0 && stage == STAGE_IDLE)

endmodule

[rtl/core/nfcs_out_reg.sv]
// Result register for the capture sequencer: holds one result until downstream takes it.
// Depends on nfcs_pkg.
module nfcs_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  nfcs_pkg::result_t res_in,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              free,
  output nfcs_pkg::result_t res_out
);
  import nfcs_pkg::*;

  logic    full;
  result_t res_q;

  assign free      = !full || out_ready;
  assign out_valid = full;
  assign res_out   = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (free) begin
      full <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

[rtl/core/neighbour_frame_capture_sequencer.sv]
// A request accepted into the input register has its result loaded into the result register
// once the result register is free; one request per cycle is sustained while out_ready is high.
// The engine computes each result combinationally between the two registers.
// Synchronous reset clears both registers' valid flags, the stage, the pending
// request and the three totals.
// Depends on nfcs_pkg, nfcs_in_reg, nfcs_engine and nfcs_out_reg.
module neighbour_frame_capture_sequencer #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] tick_number,
  input  logic        capture_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        arm_granted,
  output logic        capture_request,
  output logic [1:0]  capture_slot,
  output logic [1:0]  sequence_done,
  output logic [1:0]  current_stage,
  output logic [31:0] completed_total,
  output logic [31:0] refused_total,
  output logic [31:0] restarted_total
);
  import nfcs_pkg::*;

  event_t  ev_in, ev_held;
  result_t res_next, res_q;
  logic    held_valid, out_free, fire;

  assign ev_in.req_type    = req_type;
  assign ev_in.tick_number = tick_number;
  assign ev_in.capture_ok  = capture_ok;

  // Advance a held request only when the result register can take its result.
  assign fire = held_valid && out_free;

  nfcs_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ev_in      (ev_in),
    .advance    (fire),
    .held_valid (held_valid),
    .ev_held    (ev_held)
  );

  nfcs_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ev   (ev_held),
    .res  (res_next)
  );

  nfcs_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .res_out   (res_q)
  );

  assign arm_granted     = res_q.arm_granted;
  assign capture_request = res_q.capture_request;
  assign capture_slot    = res_q.capture_slot;
  assign sequence_done   = res_q.sequence_done;
  assign current_stage   = res_q.current_stage;
  assign completed_total = res_q.completed_total;
  assign refused_total   = res_q.refused_total;
  assign restarted_total = res_q.restarted_total;

endmodule
